[rtl/kli_pkg.sv]
// Shared constants and codes for the keyframe linear interpolator.
// No dependencies; imported by the interfaces, kli_div and the top-level core.
`default_nettype none

package kli_pkg;

  localparam int PORT_W  = 32;
  localparam int PORT_CH = 8;
  localparam int STEP_W  = 16;

  localparam int DEF_MAX_KEYFRAMES = 9;
  localparam int DEF_CHANNELS      = 8;
  localparam int DEF_VALUE_WIDTH   = 32;

  localparam logic [STEP_W-1:0] DEFAULT_STEPS = 16'd190;

  localparam logic [1:0] MODE_SAVE = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

endpackage

`default_nettype wire

[rtl/kli_if.sv]
// Valid/ready channel interfaces for pose items and pose results.
// Depends on kli_pkg for the port widths.
`default_nettype none

interface kli_in_if import kli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [PORT_W-1:0] pos_x;
  logic signed [PORT_W-1:0] pos_y;
  logic signed [PORT_W-1:0] pos_z;
  logic signed [PORT_W-1:0] body_turn;
  logic signed [PORT_W-1:0] right_leg;
  logic signed [PORT_W-1:0] left_leg;
  logic signed [PORT_W-1:0] right_arm;
  logic signed [PORT_W-1:0] left_arm;

  modport source (
    output valid, mode, pos_x, pos_y, pos_z, body_turn,
           right_leg, left_leg, right_arm, left_arm,
    input  ready
  );
  modport sink (
    input  valid, mode, pos_x, pos_y, pos_z, body_turn,
           right_leg, left_leg, right_arm, left_arm,
    output ready
  );
endinterface

interface kli_out_if import kli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PORT_W-1:0] out_x;
  logic signed [PORT_W-1:0] out_y;
  logic signed [PORT_W-1:0] out_z;
  logic signed [PORT_W-1:0] out_turn;
  logic signed [PORT_W-1:0] out_right_leg;
  logic signed [PORT_W-1:0] out_left_leg;
  logic signed [PORT_W-1:0] out_right_arm;
  logic signed [PORT_W-1:0] out_left_arm;
  logic                     playing;
  logic                     status;

  modport source (
    output valid, out_x, out_y, out_z, out_turn, out_right_leg,
           out_left_leg, out_right_arm, out_left_arm, playing, status,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_turn, out_right_leg,
           out_left_leg, out_right_arm, out_left_arm, playing, status,
    output ready
  );
endinterface

`default_nettype wire

[rtl/kli_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kli_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/kli_div.sv]
// Serial restoring divider, one quotient bit per cycle, truncating toward zero
// with saturation to the signed value range. Depends on kli_pkg.
`default_nettype none

module kli_div import kli_pkg::*; #(
  parameter int VALUE_W = DEF_VALUE_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [VALUE_W:0]   dividend,
  input  wire logic [STEP_W-1:0]  divisor,
  output logic                    done,
  output logic [VALUE_W-1:0]      quotient
);

  localparam int N     = VALUE_W + 1;
  localparam int CNT_W = $clog2(N);

  localparam logic [N-1:0]       QMAX     = {2'b00, {(VALUE_W-1){1'b1}}};
  localparam logic [N-1:0]       QMIN_MAG = {2'b01, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VMAX     = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VMIN     = {1'b1, {(VALUE_W-1){1'b0}}};

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [STEP_W-1:0] rem_r;
  logic [N-1:0]      quo_r;
  logic [STEP_W-1:0] divisor_r;

  logic [STEP_W:0]   trial;
  logic              ge;
  logic [STEP_W:0]   diff;
  logic [STEP_W-1:0] rem_nxt;
  logic [N-1:0]      mag;
  logic [N-1:0]      neg_q;

  assign mag     = dividend[VALUE_W] ? (~dividend + N'(1)) : dividend;
  assign trial   = {rem_r, quo_r[N-1]};
  assign ge      = trial >= {1'b0, divisor_r};
  assign diff    = trial - {1'b0, divisor_r};
  assign rem_nxt = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
  assign neg_q   = ~quo_r + N'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        rem_r     <= '0;
        quo_r     <= mag;
        neg_r     <= dividend[VALUE_W];
        divisor_r <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[N-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      quotient = (quo_r > QMIN_MAG) ? VMIN : neg_q[VALUE_W-1:0];
    end else begin
      quotient = (quo_r > QMAX) ? VMAX : quo_r[VALUE_W-1:0];
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

[rtl/keyframe_linear_interpolator_core.sv]
// Keyframe linear interpolator top level: sequencer, keyframe and increment RAMs.
// Save stores the pose into the keyframe RAM; a plain tick adds the stored increments to
// the pose; play start or segment advance computes the increments with the shared serial
// divider. One item is in flight; the next transfers while a result waits in the output
// register. Reset is synchronous.
// Depends on kli_pkg, kli_if, kli_ram and kli_div.
`default_nettype none

module keyframe_linear_interpolator_core import kli_pkg::*; #(
  parameter int MAX_KEYFRAMES = DEF_MAX_KEYFRAMES,
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_data,
  kli_in_if.sink                 in_ch,
  kli_out_if.source              out_ch
);

  localparam int VW       = VALUE_WIDTH;
  localparam int FW       = $clog2(MAX_KEYFRAMES + 1);
  localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KF_DEPTH = MAX_KEYFRAMES * CHANNELS;
  localparam int AW       = $clog2(KF_DEPTH);

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_SAVE, S_MI_A, S_MI_B, S_MI_D, S_MI_W, S_TK_A, S_TK_B, S_DONE
  } state_t;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VMIN : VMAX;
    end
    return s[VW-1:0];
  endfunction

  state_t            state_r;
  logic [FW-1:0]     fc_r;
  logic              play_r;
  logic [FW-1:0]     seg_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] steps_r;
  logic [CW-1:0]     ch_r;
  logic              load_pose_r;
  logic              status_r;
  logic [VW-1:0]     ka_r;
  logic [VW-1:0]     vals_r [CHANNELS];
  logic [VW-1:0]     pose_r [CHANNELS];

  logic              out_valid_r;
  logic [PORT_W-1:0] out_pose_r [PORT_CH];
  logic              out_play_r;
  logic              out_status_r;

  logic [PORT_W-1:0] in_val   [PORT_CH];
  logic [PORT_W-1:0] pose_ext [PORT_CH];

  logic [STEP_W-1:0] eff_steps;
  logic              ch_last;
  logic              seg_last;
  logic              out_load;
  logic [AW-1:0]     base_a;
  logic              kf_we;
  logic [AW-1:0]     kf_waddr;
  logic [AW-1:0]     kf_raddr;
  logic [VW-1:0]     kf_rdata;
  logic              inc_we;
  logic [VW-1:0]     inc_rdata;
  logic              div_start;
  logic [VW:0]       div_dividend;
  logic              div_done;
  logic [VW-1:0]     div_q;

  assign in_val[0] = in_ch.pos_x;
  assign in_val[1] = in_ch.pos_y;
  assign in_val[2] = in_ch.pos_z;
  assign in_val[3] = in_ch.body_turn;
  assign in_val[4] = in_ch.right_leg;
  assign in_val[5] = in_ch.left_leg;
  assign in_val[6] = in_ch.right_arm;
  assign in_val[7] = in_ch.left_arm;

  for (genvar g = 0; g < PORT_CH; g++) begin : g_pose_ext
    if (g < CHANNELS) begin : g_used
      assign pose_ext[g] = PORT_W'($signed(pose_r[g]));
    end else begin : g_unused
      assign pose_ext[g] = '0;
    end
  end

  assign eff_steps = (steps_r == '0) ? STEP_W'(1) : steps_r;
  assign ch_last   = ch_r == CW'(CHANNELS - 1);
  assign seg_last  = ({1'b0, seg_r} + (FW+1)'(3)) > {1'b0, fc_r};
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign base_a    = AW'(seg_r * CHANNELS);

  assign kf_we    = state_r == S_SAVE;
  assign kf_waddr = AW'(fc_r * CHANNELS) + AW'(ch_r);
  assign kf_raddr = base_a + AW'(ch_r) + ((state_r == S_MI_B) ? AW'(CHANNELS) : AW'(0));

  assign inc_we       = (state_r == S_MI_W) && div_done;
  assign div_start    = state_r == S_MI_D;
  assign div_dividend = {kf_rdata[VW-1], kf_rdata} - {ka_r[VW-1], ka_r};

  kli_ram #(
    .WIDTH (VW),
    .DEPTH (KF_DEPTH)
  ) u_kf_ram (
    .clk   (clk),
    .we    (kf_we),
    .waddr (kf_waddr),
    .wdata (vals_r[ch_r]),
    .raddr (kf_raddr),
    .rdata (kf_rdata)
  );

  kli_ram #(
    .WIDTH (VW),
    .DEPTH (CHANNELS)
  ) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (ch_r),
    .wdata (div_q),
    .raddr (ch_r),
    .rdata (inc_rdata)
  );

  kli_div #(
    .VALUE_W (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= '0;
      play_r      <= 1'b0;
      seg_r       <= '0;
      step_r      <= '0;
      steps_r     <= DEFAULT_STEPS;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pose_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        steps_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            for (int c = 0; c < CHANNELS; c++) begin
              vals_r[c] <= in_val[c][VW-1:0];
            end
            ch_r     <= '0;
            status_r <= 1'b0;
            case (in_ch.mode)
              MODE_SAVE: begin
                if (fc_r >= FW'(MAX_KEYFRAMES)) begin
                  status_r <= 1'b1;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_SAVE;
                end
              end
              MODE_PLAY: begin
                if (!play_r && fc_r >= FW'(2)) begin
                  play_r      <= 1'b1;
                  seg_r       <= '0;
                  step_r      <= '0;
                  load_pose_r <= 1'b1;
                  state_r     <= S_MI_A;
                end else begin
                  play_r  <= 1'b0;
                  state_r <= S_DONE;
                end
              end
              MODE_TICK: begin
                if (!play_r) begin
                  state_r <= S_DONE;
                end else if (step_r >= eff_steps) begin
                  if (seg_last) begin
                    seg_r   <= '0;
                    play_r  <= 1'b0;
                    state_r <= S_DONE;
                  end else begin
                    seg_r       <= seg_r + FW'(1);
                    step_r      <= '0;
                    load_pose_r <= 1'b0;
                    state_r     <= S_MI_A;
                  end
                end else begin
                  step_r  <= step_r + STEP_W'(1);
                  state_r <= S_TK_A;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SAVE: begin
          pose_r[ch_r] <= vals_r[ch_r];
          if (ch_last) begin
            fc_r    <= fc_r + FW'(1);
            state_r <= S_DONE;
          end else begin
            ch_r <= ch_r + CW'(1);
          end
        end
        S_MI_A: begin
          state_r <= S_MI_B;
        end
        S_MI_B: begin
          ka_r <= kf_rdata;
          if (load_pose_r) begin
            pose_r[ch_r] <= kf_rdata;
          end
          state_r <= S_MI_D;
        end
        S_MI_D: begin
          state_r <= S_MI_W;
        end
        S_MI_W: begin
          if (div_done) begin
            if (ch_last) begin
              state_r <= S_DONE;
            end else begin
              ch_r    <= ch_r + CW'(1);
              state_r <= S_MI_A;
            end
          end
        end
        S_TK_A: begin
          state_r <= S_TK_B;
        end
        S_TK_B: begin
          pose_r[ch_r] <= sat_add(pose_r[ch_r], inc_rdata);
          if (ch_last) begin
            state_r <= S_DONE;
          end else begin
            ch_r    <= ch_r + CW'(1);
            state_r <= S_TK_A;
          end
        end
        S_DONE: begin
          if (out_load) begin
            for (int c = 0; c < PORT_CH; c++) begin
              out_pose_r[c] <= pose_ext[c];
            end
            out_play_r   <= play_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = state_r == S_IDLE;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_x         = out_pose_r[0];
  assign out_ch.out_y         = out_pose_r[1];
  assign out_ch.out_z         = out_pose_r[2];
  assign out_ch.out_turn      = out_pose_r[3];
  assign out_ch.out_right_leg = out_pose_r[4];
  assign out_ch.out_left_leg  = out_pose_r[5];
  assign out_ch.out_right_arm = out_pose_r[6];
  assign out_ch.out_left_arm  = out_pose_r[7];
  assign out_ch.playing       = out_play_r;
  assign out_ch.status        = out_status_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_MI_W)
    else $error("divider result outside wait state");

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FW'(MAX_KEYFRAMES))
    else $error("keyframe count above table size");

  a_save_room: assert property (@(posedge clk) disable iff (!rst_n)
    kf_we |-> fc_r < FW'(MAX_KEYFRAMES))
    else $error("keyframe write into full table");

  a_play_segment: assert property (@(posedge clk) disable iff (!rst_n)
    play_r |-> ({1'b0, seg_r} + (FW+1)'(2)) <= {1'b0, fc_r})
    else $error("playback segment beyond stored keyframes");

endmodule

`default_nettype wire
